### src/oslr_pkg.sv
// shared types and constants of the ordinal scan log likelihood ratio block
`timescale 1ns / 1ps
package oslr_pkg;

  localparam int unsigned CNT_W    = 24;
  localparam int unsigned PROB_W   = 32;
  localparam int unsigned LN_W     = 29;
  localparam int unsigned LLR_W    = 48;
  localparam int unsigned MAG_W    = 64;
  localparam int unsigned LOG_ITER = 28;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic signed [MAG_W-1:0] LLR_MAX = 64'sd140737488355327;
  localparam logic signed [MAG_W-1:0] LLR_MIN = -64'sd140737488355328;

  localparam logic [1:0] DIR_HIGH = 2'd0;
  localparam logic [1:0] DIR_LOW  = 2'd1;

  typedef struct packed {
    logic [CNT_W-1:0] cases_inside;
    logic [CNT_W-1:0] category_total;
    logic             last_category;
  } in_req_t;

  typedef struct packed {
    logic signed [LLR_W-1:0] llr_value;
    logic                    computed;
    logic                    low_won;
  } out_rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CHECK, ST_N_RD, ST_N_LAT, ST_T_DIV, ST_T_DWAIT, ST_T_LWAIT,
    ST_K_RD, ST_K_LAT, ST_I_RD, ST_I_MUL, ST_I_CMP, ST_WR, ST_J_RD, ST_J_LAT,
    ST_J_MUL, ST_DIR_END, ST_ROUND, ST_OUT
  } oslr_state_e;

  typedef enum logic [2:0] {
    LOG_IDLE, LOG_NORM, LOG_SQ, LOG_SUB, LOG_SCALE
  } oslr_log_state_e;

endpackage

### src/oslr_div.sv
// restoring divider giving a saturated q0.32 fraction num/den, one bit per cycle
`timescale 1ns / 1ps
module oslr_div #(
  parameter int unsigned W = 58
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [31:0]  quo_o
);

  logic         busy_q, done_q;
  logic [4:0]   cnt_q;
  logic [W-1:0] rem_q, den_q, rem_nx;
  logic [31:0]  quo_q, quo_sh;
  logic [W:0]   rem_sh, rem_sub;
  logic         ge;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_nx  = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
    quo_sh  = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= num_i;
        den_q <= den_i;
        cnt_q <= '0;
        if (num_i == '0 || den_i == '0) begin
          quo_q  <= '0;
          done_q <= 1'b1;
        end else if (num_i >= den_i) begin
          quo_q  <= '1;
          done_q <= 1'b1;
        end else begin
          quo_q  <= '0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= rem_nx;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          // a nonzero fraction below one ulp still reads as one ulp
          quo_q  <= (quo_sh == '0) ? 32'd1 : quo_sh;
        end else begin
          quo_q <= quo_sh;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### src/oslr_log.sv
// natural log magnitude of a q0.32 value in q.24, log2 by repeated squaring
`timescale 1ns / 1ps
module oslr_log (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              v_i,
  output logic                     done_o,
  output logic [oslr_pkg::LN_W-1:0] mag_o
);

  oslr_pkg::oslr_log_state_e state_q, state_d;

  logic [31:0]               m_q;
  logic [4:0]                z_q, it_q;
  logic [27:0]               frac_q;
  logic [33:0]               lmag_q;
  logic [oslr_pkg::LN_W-1:0] mag_q;
  logic                      done_q;
  logic [63:0]               sq, prod, prod_rnd;
  logic [32:0]               sq_top;

  always_comb begin
    state_d = state_q;
    case (state_q)
      oslr_pkg::LOG_IDLE:  if (start_i) state_d = oslr_pkg::LOG_NORM;
      oslr_pkg::LOG_NORM:  if (m_q[31]) state_d = oslr_pkg::LOG_SQ;
      oslr_pkg::LOG_SQ:    if (it_q == 5'(oslr_pkg::LOG_ITER - 1)) state_d = oslr_pkg::LOG_SUB;
      oslr_pkg::LOG_SUB:   state_d = oslr_pkg::LOG_SCALE;
      oslr_pkg::LOG_SCALE: state_d = oslr_pkg::LOG_IDLE;
      default:             state_d = oslr_pkg::LOG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oslr_pkg::LOG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    sq       = 64'(m_q) * 64'(m_q);
    sq_top   = sq[63:31];
    prod     = 64'(lmag_q) * 64'(oslr_pkg::LN2_Q30);
    prod_rnd = prod + (64'd1 << 33);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == oslr_pkg::LOG_SCALE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      oslr_pkg::LOG_IDLE: begin
        if (start_i) begin
          m_q    <= v_i;
          z_q    <= '0;
          it_q   <= '0;
          frac_q <= '0;
        end
      end
      oslr_pkg::LOG_NORM: begin
        // one leading zero per cycle
        if (!m_q[31]) begin
          m_q <= {m_q[30:0], 1'b0};
          z_q <= z_q + 5'd1;
        end
      end
      oslr_pkg::LOG_SQ: begin
        it_q <= it_q + 5'd1;
        if (sq_top[32]) begin
          m_q    <= sq_top[32:1];
          frac_q <= {frac_q[26:0], 1'b1};
        end else begin
          m_q    <= sq_top[31:0];
          frac_q <= {frac_q[26:0], 1'b0};
        end
      end
      oslr_pkg::LOG_SUB: begin
        lmag_q <= ((34'(z_q) + 34'd1) << 28) - 34'(frac_q);
      end
      oslr_pkg::LOG_SCALE: begin
        mag_q <= prod_rnd[34 +: oslr_pkg::LN_W];
      end
      default: begin
        m_q <= m_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign mag_o  = mag_q;

endmodule

### src/ordinal_scan_log_likelihood_ratio_top.sv
// top level: category load, memories, pooling and log likelihood sequencer
`timescale 1ns / 1ps
// Usage: categories of one window come in order on the in channel
// (valid/ready), one request each, the last one flagged by last_category.
// Each accepted request is stored; requests beyond MAX_CATEGORIES are dropped but
// their last flag still closes the set. After the last request the block
// stops taking requests and computes: one null pass over the n categories,
// then per enabled direction a pooling pass (at most n(n-1)/2 compares,
// plus one write per pooled entry) and a term pass of two terms per
// category. Each log term runs the divider and then, for a nonzero
// quotient, the normalize, squaring and scaling steps of the log unit.
// A set with an empty window side skips the passes. One result then goes
// to the out register; the block waits there while a previous result is
// still held by a stalled receiver, and takes new requests again as soon
// as the result is registered.
// scan_direction is the only apb register; paddr is not decoded (pready always high).
// Reset empties the set, clears the register and drops any held result;
// memory contents are not cleared.
module ordinal_scan_log_likelihood_ratio_top #(
  parameter int unsigned MAX_CATEGORIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oslr_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oslr_pkg::out_rsp_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CW    = oslr_pkg::CNT_W;
  localparam int unsigned AW    = $clog2(MAX_CATEGORIES);
  localparam int unsigned CTW   = AW + 1;
  localparam int unsigned SUM_W = CW + AW;
  localparam int unsigned PRD_W = 2 * SUM_W;
  localparam int unsigned RAW_W = 2 * CW;
  localparam int unsigned GRP_W = 2 * SUM_W;
  localparam int unsigned MW    = oslr_pkg::MAG_W;

  oslr_pkg::oslr_state_e state_q, state_d;

  logic [1:0]       dir_q, dir_d;
  logic [CTW-1:0]   cnt_q, cnt_d, k_q, k_d, i_q, i_d, s_q, s_d, j_q, j_d;
  logic [SUM_W-1:0] w_q, w_d, u_q, u_d;
  logic             side_q, side_d, phase_null_q, phase_null_d, dir_low_q, dir_low_d;
  logic [SUM_W-1:0] acc_c_q, acc_c_d, acc_o_q, acc_o_d;
  logic             tk_nz_q, tk_nz_d;
  logic [CW-1:0]    ci_q, ci_d, ti_q, ti_d;
  logic [PRD_W-1:0] p1_q, p1_d, p2_q, p2_d;
  logic             di0_q, di0_d, dk0_q, dk0_d;
  logic [CW-1:0]    jc_q, jc_d, jo_q, jo_d, jt_q, jt_d;
  logic [SUM_W-1:0] gc_q, gc_d, go_q, go_d;
  logic [PRD_W-1:0] num_q, num_d, den_q, den_d;
  logic [CW-1:0]    weight_q, weight_d;
  logic [MW-1:0]    mag_null_q, mag_null_d, mag_dir_q, mag_dir_d;
  logic signed [MW-1:0] best_q, best_d;
  logic             low_won_q, low_won_d, computed_q, computed_d;
  logic             out_valid_q, out_valid_d;
  oslr_pkg::out_rsp_t out_q, out_d;

  // memories: raw {cases, total} per category and pooled group {c, o}
  logic [RAW_W-1:0] raw_mem [MAX_CATEGORIES];
  logic [GRP_W-1:0] grp_mem [MAX_CATEGORIES];
  logic [RAW_W-1:0] raw_rd_q, raw_wdata;
  logic [GRP_W-1:0] grp_rd_q;
  logic [AW-1:0]    rd_addr, raw_waddr;
  logic             raw_we, grp_we;

  logic [CW-1:0]    raw_c, raw_t, in_c;
  logic [SUM_W-1:0] grp_c, grp_o, di, dk, tt;
  logic             in_fire, brk, term_fin, do_high, do_low;
  logic [CTW-1:0]   i_dec, j_inc, k_inc;
  logic signed [MW-1:0] dir_val, rnd;
  logic [MW-1:0]    abs_best, rnd_mag;

  logic             div_start, div_done, log_start, log_done;
  logic [31:0]      div_quo;
  logic [oslr_pkg::LN_W-1:0] log_mag;

  oslr_div #(.W(PRD_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  oslr_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .v_i     (div_quo),
    .done_o  (log_done),
    .mag_o   (log_mag)
  );

  assign in_ready_o = (state_q == oslr_pkg::ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_c       = (in_data_i.cases_inside > in_data_i.category_total) ?
                      in_data_i.category_total : in_data_i.cases_inside;
  assign raw_c      = raw_rd_q[RAW_W-1:CW];
  assign raw_t      = raw_rd_q[CW-1:0];
  assign grp_c      = grp_rd_q[GRP_W-1:SUM_W];
  assign grp_o      = grp_rd_q[SUM_W-1:0];
  assign do_high    = (dir_q != oslr_pkg::DIR_LOW);
  assign do_low     = (dir_q != oslr_pkg::DIR_HIGH);
  assign i_dec      = i_q - CTW'(1);
  assign j_inc      = j_q + CTW'(1);
  assign k_inc      = k_q + CTW'(1);
  assign di         = (raw_t != '0) ? grp_o : '0;
  assign dk         = tk_nz_q ? acc_o_q : '0;
  assign tt         = gc_q + go_q;
  assign dir_val    = $signed(mag_null_q - mag_dir_q);
  assign abs_best   = best_q[MW-1] ? MW'(-best_q) : MW'(best_q);
  assign rnd_mag    = (abs_best + MW'(128)) >> 8;
  assign rnd        = best_q[MW-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
  assign brk        = dir_low_q ? (dk0_q || (!di0_q && (p1_q >= p2_q)))
                                : (di0_q || (!dk0_q && (p1_q <= p2_q)));
  assign term_fin   = (state_q == oslr_pkg::ST_T_DWAIT && div_done && div_quo == '0) ||
                      (state_q == oslr_pkg::ST_T_LWAIT && log_done);
  assign raw_waddr  = cnt_q[AW-1:0];
  assign raw_wdata  = {in_c, in_data_i.category_total};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    w_d          = w_q;
    u_d          = u_q;
    k_d          = k_q;
    i_d          = i_q;
    s_d          = s_q;
    j_d          = j_q;
    side_d       = side_q;
    phase_null_d = phase_null_q;
    dir_low_d    = dir_low_q;
    acc_c_d      = acc_c_q;
    acc_o_d      = acc_o_q;
    tk_nz_d      = tk_nz_q;
    ci_d         = ci_q;
    ti_d         = ti_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    di0_d        = di0_q;
    dk0_d        = dk0_q;
    jc_d         = jc_q;
    jo_d         = jo_q;
    jt_d         = jt_q;
    gc_d         = gc_q;
    go_d         = go_q;
    num_d        = num_q;
    den_d        = den_q;
    weight_d     = weight_q;
    mag_null_d   = mag_null_q;
    mag_dir_d    = mag_dir_q;
    best_d       = best_q;
    low_won_d    = low_won_q;
    computed_d   = computed_q;
    out_d        = out_q;
    out_valid_d  = (out_valid_q && out_ready_i) ? 1'b0 : out_valid_q;
    raw_we       = 1'b0;
    grp_we       = 1'b0;
    rd_addr      = '0;
    div_start    = 1'b0;
    log_start    = 1'b0;

    case (state_q)
      oslr_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (cnt_q < CTW'(MAX_CATEGORIES)) begin
            raw_we = 1'b1;
            cnt_d  = cnt_q + CTW'(1);
            w_d    = w_q + SUM_W'(in_c);
            u_d    = u_q + SUM_W'(in_data_i.category_total - in_c);
          end
          if (in_data_i.last_category) state_d = oslr_pkg::ST_CHECK;
        end
      end
      oslr_pkg::ST_CHECK: begin
        if (w_q == '0 || u_q == '0) begin
          best_d     = '0;
          low_won_d  = 1'b0;
          computed_d = 1'b0;
          state_d    = oslr_pkg::ST_OUT;
        end else begin
          j_d          = '0;
          mag_null_d   = '0;
          phase_null_d = 1'b1;
          state_d      = oslr_pkg::ST_N_RD;
        end
      end
      oslr_pkg::ST_N_RD: begin
        rd_addr = j_q[AW-1:0];
        state_d = oslr_pkg::ST_N_LAT;
      end
      oslr_pkg::ST_N_LAT: begin
        num_d    = PRD_W'(raw_t);
        den_d    = PRD_W'(w_q) + PRD_W'(u_q);
        weight_d = raw_t;
        state_d  = oslr_pkg::ST_T_DIV;
      end
      oslr_pkg::ST_T_DIV: begin
        div_start = 1'b1;
        state_d   = oslr_pkg::ST_T_DWAIT;
      end
      oslr_pkg::ST_T_DWAIT: begin
        if (div_done && div_quo != '0) begin
          log_start = 1'b1;
          state_d   = oslr_pkg::ST_T_LWAIT;
        end
      end
      oslr_pkg::ST_T_LWAIT: begin
        if (log_done) begin
          if (phase_null_q) begin
            mag_null_d = mag_null_q + MW'(weight_q) * MW'(log_mag);
          end else begin
            mag_dir_d = mag_dir_q + MW'(weight_q) * MW'(log_mag);
          end
        end
      end
      oslr_pkg::ST_K_RD: begin
        rd_addr = k_q[AW-1:0];
        state_d = oslr_pkg::ST_K_LAT;
      end
      oslr_pkg::ST_K_LAT: begin
        acc_c_d = SUM_W'(raw_c);
        acc_o_d = SUM_W'(raw_t - raw_c);
        tk_nz_d = (raw_t != '0);
        s_d     = k_q;
        i_d     = k_q;
        state_d = (k_q == '0) ? oslr_pkg::ST_WR : oslr_pkg::ST_I_RD;
      end
      oslr_pkg::ST_I_RD: begin
        rd_addr = i_dec[AW-1:0];
        i_d     = i_dec;
        state_d = oslr_pkg::ST_I_MUL;
      end
      oslr_pkg::ST_I_MUL: begin
        ci_d    = raw_c;
        ti_d    = raw_t;
        p1_d    = PRD_W'(acc_c_q) * PRD_W'(di);
        p2_d    = PRD_W'(grp_c) * PRD_W'(dk);
        di0_d   = (di == '0);
        dk0_d   = (dk == '0);
        state_d = oslr_pkg::ST_I_CMP;
      end
      oslr_pkg::ST_I_CMP: begin
        if (brk) begin
          // order broken: pool category i into the running group
          acc_c_d = acc_c_q + SUM_W'(ci_q);
          acc_o_d = acc_o_q + SUM_W'(ti_q - ci_q);
          s_d     = i_q;
          state_d = (i_q == '0) ? oslr_pkg::ST_WR : oslr_pkg::ST_I_RD;
        end else begin
          state_d = oslr_pkg::ST_WR;
        end
      end
      oslr_pkg::ST_WR: begin
        // entries s..k all take the final group counts
        grp_we = 1'b1;
        if (s_q == k_q) begin
          k_d = k_inc;
          if (k_inc == cnt_q) begin
            j_d     = '0;
            side_d  = 1'b0;
            state_d = oslr_pkg::ST_J_RD;
          end else begin
            state_d = oslr_pkg::ST_K_RD;
          end
        end else begin
          s_d = s_q + CTW'(1);
        end
      end
      oslr_pkg::ST_J_RD: begin
        rd_addr = j_q[AW-1:0];
        state_d = oslr_pkg::ST_J_LAT;
      end
      oslr_pkg::ST_J_LAT: begin
        jc_d    = raw_c;
        jo_d    = raw_t - raw_c;
        jt_d    = raw_t;
        gc_d    = grp_c;
        go_d    = grp_o;
        state_d = oslr_pkg::ST_J_MUL;
      end
      oslr_pkg::ST_J_MUL: begin
        if (side_q) begin
          num_d    = PRD_W'(go_q) * PRD_W'(jt_q);
          den_d    = PRD_W'(u_q) * PRD_W'(tt);
          weight_d = jo_q;
        end else begin
          num_d    = PRD_W'(gc_q) * PRD_W'(jt_q);
          den_d    = PRD_W'(w_q) * PRD_W'(tt);
          weight_d = jc_q;
        end
        state_d = oslr_pkg::ST_T_DIV;
      end
      oslr_pkg::ST_DIR_END: begin
        if (!dir_low_q) begin
          best_d    = dir_val;
          low_won_d = 1'b0;
          if (do_low) begin
            dir_low_d = 1'b1;
            k_d       = '0;
            mag_dir_d = '0;
            state_d   = oslr_pkg::ST_K_RD;
          end else begin
            state_d = oslr_pkg::ST_ROUND;
          end
        end else begin
          if (!do_high || dir_val > best_q) begin
            best_d    = dir_val;
            low_won_d = 1'b1;
          end
          state_d = oslr_pkg::ST_ROUND;
        end
      end
      oslr_pkg::ST_ROUND: begin
        computed_d = 1'b1;
        if (rnd > oslr_pkg::LLR_MAX) begin
          best_d = oslr_pkg::LLR_MAX;
        end else if (rnd < oslr_pkg::LLR_MIN) begin
          best_d = oslr_pkg::LLR_MIN;
        end else begin
          best_d = rnd;
        end
        state_d = oslr_pkg::ST_OUT;
      end
      oslr_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.llr_value    = best_q[oslr_pkg::LLR_W-1:0];
          out_d.computed     = computed_q;
          out_d.low_won      = low_won_q;
          cnt_d              = '0;
          w_d                = '0;
          u_d                = '0;
          state_d            = oslr_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = oslr_pkg::ST_LOAD;
      end
    endcase

    // end of one log term, taken or skipped for a zero fraction
    if (term_fin) begin
      if (phase_null_q) begin
        j_d = j_inc;
        if (j_inc == cnt_q) begin
          k_d          = '0;
          mag_dir_d    = '0;
          phase_null_d = 1'b0;
          dir_low_d    = (dir_q == oslr_pkg::DIR_LOW);
          state_d      = oslr_pkg::ST_K_RD;
        end else begin
          state_d = oslr_pkg::ST_N_RD;
        end
      end else if (!side_q) begin
        side_d  = 1'b1;
        state_d = oslr_pkg::ST_J_MUL;
      end else begin
        side_d  = 1'b0;
        j_d     = j_inc;
        state_d = (j_inc == cnt_q) ? oslr_pkg::ST_DIR_END : oslr_pkg::ST_J_RD;
      end
    end
  end

  // configuration register
  always_comb begin
    dir_d = dir_q;
    if (psel && penable && pwrite && pready) dir_d = pwdata[1:0];
  end

  assign pready = 1'b1;
  assign prdata = {30'd0, dir_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= oslr_pkg::ST_LOAD;
      dir_q        <= oslr_pkg::DIR_HIGH;
      cnt_q        <= '0;
      w_q          <= '0;
      u_q          <= '0;
      k_q          <= '0;
      i_q          <= '0;
      s_q          <= '0;
      j_q          <= '0;
      side_q       <= 1'b0;
      phase_null_q <= 1'b0;
      dir_low_q    <= 1'b0;
      mag_null_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dir_q        <= dir_d;
      cnt_q        <= cnt_d;
      w_q          <= w_d;
      u_q          <= u_d;
      k_q          <= k_d;
      i_q          <= i_d;
      s_q          <= s_d;
      j_q          <= j_d;
      side_q       <= side_d;
      phase_null_q <= phase_null_d;
      dir_low_q    <= dir_low_d;
      mag_null_q   <= mag_null_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_c_q    <= acc_c_d;
    acc_o_q    <= acc_o_d;
    tk_nz_q    <= tk_nz_d;
    ci_q       <= ci_d;
    ti_q       <= ti_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    di0_q      <= di0_d;
    dk0_q      <= dk0_d;
    jc_q       <= jc_d;
    jo_q       <= jo_d;
    jt_q       <= jt_d;
    gc_q       <= gc_d;
    go_q       <= go_d;
    num_q      <= num_d;
    den_q      <= den_d;
    weight_q   <= weight_d;
    mag_dir_q  <= mag_dir_d;
    best_q     <= best_d;
    low_won_q  <= low_won_d;
    computed_q <= computed_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
    raw_rd_q <= raw_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) grp_mem[s_q[AW-1:0]] <= {acc_c_q, acc_o_q};
    grp_rd_q <= grp_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/oslr_checker.sv
// port level checks of the top level and their binding
`timescale 1ns / 1ps
module oslr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input oslr_pkg::out_rsp_t out_data_o,
  input logic               pready
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a set with an empty side reports a plain zero
  a_not_computed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.computed |->
      out_data_o.llr_value == '0 && !out_data_o.low_won)
    else $error("nonzero result without a computed ratio");

  // a new result only comes out of the compute phase, never during load
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while loading");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind ordinal_scan_log_likelihood_ratio_top oslr_checker u_oslr_checker (.*);

### tb/oslr_checker.sv
// checker: watches both channels and the apb port, predicts each ratio and compares
`timescale 1ns / 1ps
module oslr_scoreboard #(
  parameter int unsigned MAX_CAT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  oslr_pkg::in_req_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  oslr_pkg::out_rsp_t           out_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [1:0]                   paddr_i,
  input  logic [31:0]                  pwdata_i,
  input  logic                         pready_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o
);

  localparam logic [1:0] SCAN_DIR_ADDR = 2'd0;

  logic [63:0]        cat_inside[MAX_CAT];
  logic [63:0]        cat_total[MAX_CAT];
  logic [63:0]        win_inside;
  logic [63:0]        win_outside;
  int unsigned        n_loaded;
  logic [1:0]         scan_dir;
  oslr_pkg::out_rsp_t ratio_q[$];
  int unsigned        mismatches;

  assign mismatches_o = mismatches;
  assign pending_o    = ratio_q.size();

  // floor(num / den) in Q0.32, saturated at one, at least one ulp when nonzero
  function automatic logic [31:0] ratio_q32(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = '0;
    if (num == 0 || den == 0) return '0;
    if (num >= den) return 32'hFFFF_FFFF;
    for (int b = 0; b < 32; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    if (quo == 0) quo = 64'd1;
    return quo[31:0];
  endfunction

  // |ln(v / 2^32)| in Q.24 via log2 by repeated squaring
  function automatic logic [63:0] neg_ln_q24(logic [31:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lmag;
    e = 31;
    while (e > 0 && v[e] == 1'b0) e--;
    m = 64'(v) << (31 - e);
    frac = '0;
    for (int b = 0; b < oslr_pkg::LOG_ITER; b++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    lmag = (64'(32 - e) << 28) - frac;
    return (lmag * 64'(oslr_pkg::LN2_Q30) + (64'd1 << 33)) >> 34;
  endfunction

  // zero total or zero outside count counts as an infinite rate
  function automatic bit breaks_order(bit high, logic [63:0] cs[MAX_CAT],
                                      logic [63:0] os[MAX_CAT], int k, int i);
    logic [63:0] nk, dk, ni, di;
    nk = cs[k];
    dk = (cat_total[k] != 0) ? os[k] : 64'd0;
    ni = cs[i];
    di = (cat_total[i] != 0) ? os[i] : 64'd0;
    if (high) return di == 0 || (dk != 0 && nk * di <= ni * dk);
    return dk == 0 || (di != 0 && nk * di >= ni * dk);
  endfunction

  // pooled probabilities for one direction, returns the log likelihood magnitude
  function automatic logic [63:0] pooled_loglik(bit high);
    logic [63:0] cs[MAX_CAT];
    logic [63:0] os[MAX_CAT];
    logic [63:0] mag, c, o, tt;
    logic [31:0] p, q;
    int          i;
    mag = '0;
    for (int k = 0; k < n_loaded; k++) begin
      cs[k] = cat_inside[k];
      os[k] = cat_total[k] - cat_inside[k];
      i = k;
      while (i > 0) begin
        i--;
        if (!breaks_order(high, cs, os, k, i)) break;
        c = '0;
        o = '0;
        for (int j = i; j <= k; j++) begin
          c += cat_inside[j];
          o += cat_total[j] - cat_inside[j];
        end
        for (int j = i; j <= k; j++) begin
          cs[j] = c;
          os[j] = o;
        end
      end
    end
    for (int j = 0; j < n_loaded; j++) begin
      tt = cs[j] + os[j];
      c  = cat_inside[j];
      o  = cat_total[j] - c;
      p  = (tt != 0) ? ratio_q32(cs[j] * cat_total[j], win_inside * tt) : '0;
      q  = (tt != 0) ? ratio_q32(os[j] * cat_total[j], win_outside * tt) : '0;
      if (p != 0) mag += c * neg_ln_q24(p);
      if (q != 0) mag += o * neg_ln_q24(q);
    end
    return mag;
  endfunction

  // loads one category; the last one of a set yields one ratio
  function automatic void load_category(oslr_pkg::in_req_t r);
    logic [63:0]        c, t, nsum, mag;
    logic signed [63:0] null_ll, hi, lo, rr;
    oslr_pkg::out_rsp_t res;
    bit                 do_high, do_low;
    c = 64'(r.cases_inside);
    t = 64'(r.category_total);
    if (n_loaded < MAX_CAT) begin
      if (c > t) c = t;
      cat_inside[n_loaded] = c;
      cat_total[n_loaded]  = t;
      win_inside  += c;
      win_outside += t - c;
      n_loaded++;
    end
    if (!r.last_category) return;
    nsum = win_inside + win_outside;
    mag = '0;
    for (int j = 0; j < n_loaded; j++)
      if (cat_total[j] != 0)
        mag += cat_total[j] * neg_ln_q24(ratio_q32(cat_total[j], nsum));
    null_ll = -$signed(mag);
    res = '0;
    if (win_inside != 0 && win_outside != 0) begin
      do_high = scan_dir != oslr_pkg::DIR_LOW;
      do_low  = scan_dir != oslr_pkg::DIR_HIGH;
      res.computed = 1'b1;
      hi = '0;
      if (do_high) hi = -$signed(pooled_loglik(1'b1)) - null_ll;
      if (do_low) begin
        lo = -$signed(pooled_loglik(1'b0)) - null_ll;
        if (!do_high || lo > hi) begin
          hi = lo;
          res.low_won = 1'b1;
        end
      end
      // Q.24 to Q.16, half away from zero
      if (hi >= 0) rr = $signed((($unsigned(hi)) + 64'd128) >> 8);
      else rr = -$signed((($unsigned(-hi)) + 64'd128) >> 8);
      if (rr > oslr_pkg::LLR_MAX) rr = oslr_pkg::LLR_MAX;
      if (rr < oslr_pkg::LLR_MIN) rr = oslr_pkg::LLR_MIN;
      res.llr_value = rr[oslr_pkg::LLR_W-1:0];
    end
    ratio_q.insert(ratio_q.size(), res);
    n_loaded    = 0;
    win_inside  = '0;
    win_outside = '0;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    oslr_pkg::out_rsp_t want;
    if (!rst_ni) begin
      n_loaded    <= 0;
      win_inside  <= '0;
      win_outside <= '0;
      scan_dir    <= oslr_pkg::DIR_HIGH;
      mismatches  <= 0;
      ratio_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SCAN_DIR_ADDR)
        scan_dir <= pwdata_i[1:0];
      if (in_valid_i && in_ready_i) load_category(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (ratio_q.size() == 0) begin
          report("unexpected ratio", 64'(out_data_i), '0);
        end else begin
          want = ratio_q.pop_front();
          if (out_data_i.llr_value !== want.llr_value)
            report("llr_value", 64'(out_data_i.llr_value), 64'(want.llr_value));
          if (out_data_i.computed !== want.computed)
            report("computed", 64'(out_data_i.computed), 64'(want.computed));
          if (out_data_i.low_won !== want.low_won)
            report("low_won", 64'(out_data_i.low_won), 64'(want.low_won));
        end
      end
    end
  end

endmodule

### tb/ordinal_scan_log_likelihood_ratio_top_tb.sv
// testbench top: clock, reset, category requests, apb writes and the verdict
`timescale 1ns / 1ps
module ordinal_scan_log_likelihood_ratio_top_tb;

  localparam int unsigned MAX_CAT       = 16;
  localparam int unsigned CYCLE_LIMIT   = 12_000_000;
  localparam int unsigned TARGET_ITEMS  = 2000;
  localparam logic [1:0]  SCAN_DIR_ADDR = 2'd0;
  localparam logic [1:0]  DIR_BOTH      = 2'd2;
  localparam logic [1:0]  DIR_ALIAS     = 2'd3;

  typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_NO_INSIDE, MIX_NO_OUTSIDE, MIX_FULL} mix_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  oslr_pkg::in_req_t  in_data;
  logic               out_valid;
  logic               out_ready;
  oslr_pkg::out_rsp_t out_data;
  logic               psel, penable, pwrite, pready;
  logic [1:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int unsigned        mismatches, pending;
  int unsigned        cycles = 0;
  int unsigned        items_sent;
  int unsigned        stall_left;
  bit                 quiet;

  ordinal_scan_log_likelihood_ratio_top #(.MAX_CATEGORIES(MAX_CAT)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  oslr_scoreboard #(.MAX_CAT(MAX_CAT)) u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  task automatic send_request(logic [23:0] c, logic [23:0] t, logic last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cases_inside: c, category_total: t, last_category: last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the scoreboard see the last accepted request first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_scan_dir(logic [1:0] dir);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SCAN_DIR_ADDR;
    pwdata  <= {30'd0, dir};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_set(int unsigned n, mix_e mix);
    logic [23:0] c, t;
    int unsigned scale;
    scale = $urandom_range(3) == 0 ? 24'hFFFFFF : $urandom_range(200, 2);
    for (int unsigned k = 0; k < n; k++) begin
      case (mix)
        MIX_RANDOM: begin
          c = 24'($urandom());
          t = 24'($urandom());
        end
        MIX_NO_INSIDE: begin
          t = 24'($urandom_range(scale));
          c = 24'd0;
        end
        MIX_NO_OUTSIDE: begin
          t = 24'($urandom_range(scale));
          c = t;
        end
        MIX_FULL: begin
          t = 24'hFFFFFF;
          c = ($urandom_range(1) == 0) ? 24'hFFFFFF : 24'($urandom());
        end
        default: begin
          t = 24'($urandom_range(scale));
          // now and then above the total to hit the clamp
          c = ($urandom_range(9) == 0) ? t + 24'($urandom_range(5)) :
                                         24'($urandom_range(t));
        end
      endcase
      send_request(c, t, k == n - 1);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned roll;
    mix_e        mix;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    items_sent = 0;
    quiet      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sets under the reset direction
    send_request(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_request(24'h000000, 24'hFFFFFF, 1'b1);
    send_request(24'd3, 24'd10, 1'b1);
    send_request(24'd0, 24'd0, 1'b0);
    send_request(24'd9, 24'd4, 1'b0);
    send_request(24'd1, 24'd7, 1'b1);
    send_set(3, MIX_NO_INSIDE);
    send_set(3, MIX_NO_OUTSIDE);
    write_scan_dir(oslr_pkg::DIR_LOW);
    send_set(4, MIX_SMALL);
    send_set(2, MIX_FULL);
    write_scan_dir(DIR_BOTH);
    // more categories than the store holds
    send_set(MAX_CAT + 2, MIX_SMALL);
    write_scan_dir(DIR_ALIAS);
    send_set(3, MIX_RANDOM);

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(30) == 0) write_scan_dir(2'($urandom_range(3)));
      if ($urandom_range(20) == 0) drain();
      if ($urandom_range(15) == 0) quiet = ~quiet;
      roll = $urandom_range(99);
      n = (roll < 92) ? $urandom_range(6, 1) : $urandom_range(MAX_CAT + 2, 7);
      roll = $urandom_range(99);
      if (roll < 70) mix = MIX_SMALL;
      else if (roll < 82) mix = MIX_RANDOM;
      else if (roll < 88) mix = MIX_FULL;
      else if (roll < 94) mix = MIX_NO_INSIDE;
      else mix = MIX_NO_OUTSIDE;
      send_set(n, mix);
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### ordinal_scan_log_likelihood_ratio_top.f
src/oslr_pkg.sv
src/oslr_div.sv
src/oslr_log.sv
src/ordinal_scan_log_likelihood_ratio_top.sv
src/oslr_checker.sv
tb/oslr_checker.sv
tb/ordinal_scan_log_likelihood_ratio_top_tb.sv
